@@ sv/tace_pkg.sv @@
`timescale 1ns / 1ps
package tace_pkg;
    typedef enum logic [4:0] {
        K_PRELOAD = 5'd0, K_COPY = 5'd1, K_TEXT = 5'd2, K_VOUT = 5'd3, K_IN = 5'd4,
        K_ADD = 5'd5, K_SUB = 5'd6, K_MUL = 5'd7, K_DIV = 5'd8, K_MOD = 5'd9,
        K_GOTO = 5'd10, K_BEQ = 5'd11, K_BNE = 5'd12, K_BLT = 5'd13, K_BGT = 5'd14,
        K_BLE = 5'd15, K_BGE = 5'd16, K_RET = 5'd17, K_END = 5'd18
    } t_kind;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned ADDR_W = 10;
    localparam int unsigned IDX_W  = 10;

    // The index wraps by truncation, so the program depth is a power of two.
    localparam int unsigned PROGRAM_DEPTH = 1024;

    typedef struct packed {
        logic              start;
        logic              is_mod;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } t_div_rsp;
endpackage

@@ sv/tace_div.sv @@
`timescale 1ns / 1ps
module tace_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tace_pkg::t_div_req i_req,
    output tace_pkg::t_div_rsp o_rsp
);
    import tace_pkg::*;

    // Restoring divider on magnitudes, one quotient bit per cycle.
    logic [WORD_W-1:0] r_quo, n_quo;
    logic [WORD_W:0]   r_rem, n_rem;
    logic [WORD_W-1:0] r_den;
    logic [5:0]        r_cnt;
    logic              r_busy, r_done, r_neg_q, r_neg_r, r_mod;
    logic [WORD_W:0]   w_shift, w_diff;
    logic [WORD_W-1:0] w_mag_a, w_mag_b, w_q, w_r;

    assign w_mag_a = i_req.dividend[WORD_W-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;
    assign w_mag_b = i_req.divisor[WORD_W-1] ? (~i_req.divisor + 1'b1) : i_req.divisor;
    assign w_shift = {r_rem[WORD_W-1:0], r_quo[WORD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_comb begin
        n_quo = {r_quo[WORD_W-2:0], 1'b0};
        n_rem = w_shift;
        if (!w_diff[WORD_W]) begin
            n_rem    = w_diff;
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_cnt   <= 6'(WORD_W);
                r_quo   <= w_mag_a;
                r_rem   <= '0;
                r_den   <= w_mag_b;
                r_neg_q <= i_req.dividend[WORD_W-1] ^ i_req.divisor[WORD_W-1];
                r_neg_r <= i_req.dividend[WORD_W-1];
                r_mod   <= i_req.is_mod;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign w_q = r_neg_q ? (~r_quo + 1'b1) : r_quo;
    assign w_r = r_neg_r ? (~r_rem[WORD_W-1:0] + 1'b1) : r_rem[WORD_W-1:0];
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_mod ? w_r : w_q;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start) else $error("divider restarted while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
`endif
endmodule

@@ sv/three_address_code_executor_unit.sv @@
`timescale 1ns / 1ps
// Three-address instruction executor.
// Input channel (i_valid/o_ready) takes one decoded instruction per transaction;
// output channel (o_valid/i_ready) gives one result per instruction: next index,
// output word with its flag, halted flag and divide error flag.
// Operands live in a word memory with registered reads; word address
// is the byte address divided by four, words beyond DATA_WORDS read as zero
// and ignore writes.
// An accepted instruction goes through the states S_RDA, S_RDB, S_EXEC, S_DIV
// (only for divide and modulo with a nonzero divisor) and S_OUT; after a halt
// it skips them. Each result passes the pending register, then the output register.
// One instruction is in flight at a time, so there is no memory hazard.
// The next instruction is accepted as soon as the result sits in the output
// register, even while the receiver stalls; it waits in the core until the
// output register is free.
// Reset clears the program index, the halt flag and all handshake state; the
// data memory is not cleared and a word must be written before it is read.
// After ret or end every later instruction only returns the held index with
// halted set.
module three_address_code_executor_unit #(
    parameter int unsigned DATA_WORDS    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_kind,
    input  logic [9:0]  i_addr_a,
    input  logic [9:0]  i_addr_b,
    input  logic [9:0]  i_addr_dest,
    input  logic [9:0]  i_branch_target,
    input  logic signed [31:0] i_data_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_next_index,
    output logic        o_out_valid,
    output logic signed [31:0] o_out_value,
    output logic        o_halted,
    output logic        o_div_error
);
    import tace_pkg::*;

    localparam int unsigned MW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int unsigned PW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;

    typedef enum logic [2:0] {S_IDLE, S_RDA, S_RDB, S_EXEC, S_DIV, S_OUT} t_state;

    logic [WORD_W-1:0] r_mem [DATA_WORDS];
    logic [WORD_W-1:0] r_rdata, r_va;
    logic              r_rd_ok, r_va_ok;
    t_state            r_state;
    logic [4:0]        r_kind;
    logic [ADDR_W-1:0] r_b, r_d, r_tgt;
    logic [WORD_W-1:0] r_dv;
    logic [PW-1:0]     r_pc;
    logic              r_halt;
    logic              r_ov, r_hl, r_de;
    logic [WORD_W-1:0] r_oval;
    logic [IDX_W-1:0]  r_oidx;
    // Pending result from the core waiting for the output register.
    logic              r_pend;
    logic              r_p_ov, r_p_hl, r_p_de;
    logic [WORD_W-1:0] r_p_oval;
    logic [IDX_W-1:0]  r_p_idx;

    logic [ADDR_W-1:0] w_raddr, w_waddr;
    logic              w_we;
    logic [WORD_W-1:0] w_wdata, w_va, w_vb, w_alu;
    logic [63:0]       w_prod;
    logic              w_take, w_lt, w_eq;
    logic [PW-1:0]     w_pc_next;
    t_div_req          w_dreq;
    t_div_rsp          w_drsp;
    logic              w_out_free;

    function automatic logic in_range(input logic [ADDR_W-1:0] a);
        in_range = (32'(a[ADDR_W-1:2]) < DATA_WORDS);
    endfunction

    assign w_out_free = !o_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && !r_pend;
    assign w_raddr    = (r_state == S_IDLE) ? i_addr_a : r_b;

    always_ff @(posedge i_clk) begin
        if (in_range(w_raddr)) r_rdata <= r_mem[MW'(w_raddr[ADDR_W-1:2])];
        r_rd_ok <= in_range(w_raddr);
        if (w_we && in_range(w_waddr)) r_mem[MW'(w_waddr[ADDR_W-1:2])] <= w_wdata;
    end

    assign w_va  = r_va_ok ? r_va : '0;
    assign w_vb  = r_rd_ok ? r_rdata : '0;
    assign w_eq  = (w_va == w_vb);
    assign w_lt  = ($signed(w_va) < $signed(w_vb));
    assign w_prod = 64'(w_va) * 64'(w_vb);
    assign w_pc_next = r_pc + 1'b1;
    assign w_waddr = r_d;

    always_comb begin
        w_alu  = '0;
        w_take = 1'b0;
        unique case (r_kind)
            K_PRELOAD, K_IN: w_alu = r_dv;
            K_COPY:  w_alu = w_va;
            K_ADD:   w_alu = w_va + w_vb;
            K_SUB:   w_alu = w_va - w_vb;
            K_MUL:   w_alu = w_prod[WORD_W-1:0];
            K_GOTO:  w_take = 1'b1;
            K_BEQ:   w_take = w_eq;
            K_BNE:   w_take = !w_eq;
            K_BLT:   w_take = w_lt;
            K_BGT:   w_take = !w_lt && !w_eq;
            K_BLE:   w_take = w_lt || w_eq;
            K_BGE:   w_take = !w_lt;
            default: w_alu = '0;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_wdata = w_alu;
        if (r_state == S_EXEC) begin
            w_we = (r_kind == K_PRELOAD) || (r_kind == K_IN) || (r_kind == K_COPY) ||
                   (r_kind == K_ADD) || (r_kind == K_SUB) || (r_kind == K_MUL);
        end else if (r_state == S_DIV && w_drsp.done) begin
            w_we    = 1'b1;
            w_wdata = w_drsp.result;
        end
    end

    assign w_dreq.start    = (r_state == S_EXEC) &&
                             ((r_kind == K_DIV) || (r_kind == K_MOD)) && (w_vb != '0);
    assign w_dreq.is_mod   = (r_kind == K_MOD);
    assign w_dreq.dividend = w_va;
    assign w_dreq.divisor  = w_vb;

    tace_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_halt  <= 1'b0;
            r_pend  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (r_pend && w_out_free) begin
                o_valid <= 1'b1;
                r_ov    <= r_p_ov;
                r_oval  <= r_p_oval;
                r_hl    <= r_p_hl;
                r_de    <= r_p_de;
                r_oidx  <= r_p_idx;
                r_pend  <= 1'b0;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_kind <= i_kind;
                        r_b    <= i_addr_b;
                        r_d    <= i_addr_dest;
                        r_tgt  <= i_branch_target;
                        r_dv   <= i_data_value;
                        if (r_halt) begin
                            r_pend   <= 1'b1;
                            r_p_ov   <= 1'b0;
                            r_p_oval <= '0;
                            r_p_hl   <= 1'b1;
                            r_p_de   <= 1'b0;
                            r_p_idx  <= IDX_W'(r_pc);
                        end else begin
                            r_state <= S_RDA;
                        end
                    end
                end
                S_RDA: begin
                    r_va    <= r_rdata;
                    r_va_ok <= r_rd_ok;
                    r_state <= S_RDB;
                end
                S_RDB: r_state <= S_EXEC;
                S_EXEC: begin
                    r_p_ov   <= (r_kind == K_VOUT);
                    r_p_oval <= (r_kind == K_VOUT) ? w_va : '0;
                    r_p_de   <= ((r_kind == K_DIV) || (r_kind == K_MOD)) && (w_vb == '0);
                    if ((r_kind == K_RET) || (r_kind == K_END)) begin
                        r_halt  <= 1'b1;
                        r_p_hl  <= 1'b1;
                        r_p_idx <= IDX_W'(r_pc);
                    end else begin
                        r_p_hl  <= 1'b0;
                        r_pc    <= w_take ? PW'(r_tgt) : w_pc_next;
                        r_p_idx <= w_take ? IDX_W'(PW'(r_tgt)) : IDX_W'(w_pc_next);
                    end
                    if (w_dreq.start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV: if (w_drsp.done) r_state <= S_OUT;
                S_OUT: begin
                    r_pend  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_next_index = r_oidx;
    assign o_out_valid  = r_ov;
    assign o_out_value  = r_oval;
    assign o_halted     = r_hl;
    assign o_div_error  = r_de;

`ifndef NO_ASSERTIONS
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt flag dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_halt_holds_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_halt) && r_halt) |-> $stable(r_pc)) else $error("index moved after halt");
`endif
endmodule

@@ verif/tb_three_address_code_executor_unit.sv @@
`timescale 1ns / 1ps
module tb_three_address_code_executor_unit;
    import tace_pkg::*;

    localparam int unsigned MEM_WORDS    = 256;
    localparam int unsigned PHASE_ITEMS  = 380;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned TAIL_CYCLES  = 60;
    localparam int unsigned LONG_STALL   = 400;
    localparam logic [4:0]  UNUSED_FIRST = 5'd19;
    localparam logic [4:0]  UNUSED_LAST  = 5'd31;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [4:0]         kind;
        logic [9:0]         addr_a;
        logic [9:0]         addr_b;
        logic [9:0]         addr_dest;
        logic [9:0]         target;
        logic signed [31:0] value;
        int unsigned        send_idle;
        int unsigned        recv_idle;
        bit                 drain;
    } t_instr;

    typedef struct {
        logic [9:0]         next_index;
        logic               out_valid;
        logic signed [31:0] out_value;
        logic               halted;
        logic               div_error;
    } t_exec_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [4:0]         i_kind = '0;
    logic [9:0]         i_addr_a = '0;
    logic [9:0]         i_addr_b = '0;
    logic [9:0]         i_addr_dest = '0;
    logic [9:0]         i_branch_target = '0;
    logic signed [31:0] i_data_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [9:0]         o_next_index;
    logic               o_out_valid;
    logic signed [31:0] o_out_value;
    logic               o_halted;
    logic               o_div_error;

    t_instr       pending_instrs[$];
    t_exec_result expected_results[$];

    // Predictor state.
    logic [31:0] model_mem[MEM_WORDS];
    logic [9:0]  model_pc = '0;
    bit          model_halted = 1'b0;

    // Generator bookkeeping: words that hold a value.
    bit          word_written[MEM_WORDS];
    int unsigned written_words[$];

    int unsigned phase_send_idle = 0;
    int unsigned phase_recv_idle = 0;
    int unsigned total_items = 0;
    int unsigned accepted_count = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    bit          input_taken = 1'b0;
    bit          long_hold = 1'b0;

    three_address_code_executor_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_addr_a        (i_addr_a),
        .i_addr_b        (i_addr_b),
        .i_addr_dest     (i_addr_dest),
        .i_branch_target (i_branch_target),
        .i_data_value    (i_data_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_next_index    (o_next_index),
        .o_out_valid     (o_out_valid),
        .o_out_value     (o_out_value),
        .o_halted        (o_halted),
        .o_div_error     (o_div_error)
    );

    always #10 i_clk = ~i_clk;

    function automatic void mark_written(logic [9:0] byte_addr);
        int unsigned w;
        w = byte_addr >> 2;
        if (!word_written[w]) begin
            word_written[w] = 1'b1;
            written_words.insert(written_words.size(), w);
        end
    endfunction

    function automatic logic [9:0] pick_source();
        int unsigned w;
        w = written_words[$urandom_range(written_words.size() - 1)];
        return 10'(w * 4 + $urandom_range(3));
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return INT_MIN;
            1: return INT_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'($signed($urandom_range(20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_instr(logic [4:0] kind, logic [9:0] a, logic [9:0] b,
                                        logic [9:0] d, logic [9:0] t,
                                        logic signed [31:0] v, bit drain);
        t_instr it;
        it.kind = kind;
        it.addr_a = a;
        it.addr_b = b;
        it.addr_dest = d;
        it.target = t;
        it.value = v;
        it.send_idle = phase_send_idle;
        it.recv_idle = phase_recv_idle;
        it.drain = drain;
        pending_instrs.insert(pending_instrs.size(), it);
        total_items++;
        if (kind inside {K_PRELOAD, K_COPY, K_IN, K_ADD, K_SUB, K_MUL})
            mark_written(d);
    endfunction

    // Divide and modulo write only to words that already hold a value, so a
    // zero divisor never leaves the generator guessing about memory contents.
    function automatic void queue_random_instr(bit drain);
        logic [4:0] kind;
        logic [9:0] d;
        if ($urandom_range(99) < 4)
            kind = 5'($urandom_range(UNUSED_FIRST, UNUSED_LAST));
        else
            kind = 5'($urandom_range(K_PRELOAD, K_BGE));
        d = (kind == K_DIV || kind == K_MOD) ? pick_source() : 10'($urandom_range(1023));
        queue_instr(kind, pick_source(), pick_source(), d, 10'($urandom_range(1023)),
                    pick_value(), drain);
    endfunction

    function automatic logic [31:0] model_read(logic [9:0] byte_addr);
        return (byte_addr >> 2) < MEM_WORDS ? model_mem[byte_addr >> 2] : 32'd0;
    endfunction

    function automatic void model_write(logic [9:0] byte_addr, logic [31:0] v);
        if ((byte_addr >> 2) < MEM_WORDS)
            model_mem[byte_addr >> 2] = v;
    endfunction

    function automatic void execute_instr(logic [4:0] kind, logic [9:0] a, logic [9:0] b,
                                          logic [9:0] d, logic [9:0] t,
                                          logic [31:0] v);
        t_exec_result r;
        logic [31:0] va, vb;
        longint sa, sb, q;
        bit taken;
        r = '{default: '0};
        taken = 1'b0;
        if (model_halted) begin
            r.next_index = model_pc;
            r.halted = 1'b1;
            expected_results.insert(expected_results.size(), r);
            return;
        end
        r.next_index = model_pc + 10'd1;
        va = model_read(a);
        vb = model_read(b);
        sa = longint'($signed(va));
        sb = longint'($signed(vb));
        case (kind)
            K_PRELOAD, K_IN: model_write(d, v);
            K_COPY: model_write(d, va);
            K_VOUT: begin
                r.out_valid = 1'b1;
                r.out_value = va;
            end
            K_ADD: model_write(d, va + vb);
            K_SUB: model_write(d, va - vb);
            K_MUL: model_write(d, va * vb);
            K_DIV, K_MOD: begin
                if (vb == 32'd0) begin
                    r.div_error = 1'b1;
                end else begin
                    q = (kind == K_DIV) ? sa / sb : sa % sb;
                    model_write(d, q[31:0]);
                end
            end
            K_GOTO: taken = 1'b1;
            K_BEQ: taken = sa == sb;
            K_BNE: taken = sa != sb;
            K_BLT: taken = sa < sb;
            K_BGT: taken = sa > sb;
            K_BLE: taken = sa <= sb;
            K_BGE: taken = sa >= sb;
            K_RET, K_END: begin
                model_halted = 1'b1;
                r.next_index = model_pc;
            end
            default: ;
        endcase
        if (taken)
            r.next_index = t;
        model_pc = r.next_index;
        r.halted = model_halted;
        expected_results.insert(expected_results.size(), r);
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, field,
                 got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_three_address_code_executor_unit: done, errors");
            $finish;
        end
    end

    // Input side: predict on every accepted transaction.
    always @(posedge i_clk) begin
        input_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            execute_instr(i_kind, i_addr_a, i_addr_b, i_addr_dest, i_branch_target,
                          i_data_value);
            accepted_count <= accepted_count + 1;
        end
    end

    // Driver.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || input_taken)) begin
            if (pending_instrs.size() > 0
                    && !(pending_instrs[0].drain && expected_results.size() != 0)
                    && $urandom_range(99) >= pending_instrs[0].send_idle) begin
                i_kind          <= pending_instrs[0].kind;
                i_addr_a        <= pending_instrs[0].addr_a;
                i_addr_b        <= pending_instrs[0].addr_b;
                i_addr_dest     <= pending_instrs[0].addr_dest;
                i_branch_target <= pending_instrs[0].target;
                i_data_value    <= pending_instrs[0].value;
                phase_recv_idle <= pending_instrs[0].recv_idle;
                i_valid         <= 1'b1;
                void'(pending_instrs.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= i_rst_n && !long_hold && $urandom_range(99) >= phase_recv_idle;
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result transaction at cycle %0d", cycle_count);
                error_count++;
            end else begin
                if (o_next_index !== expected_results[0].next_index)
                    report_mismatch("next_index", o_next_index,
                                    expected_results[0].next_index);
                if (o_out_valid !== expected_results[0].out_valid)
                    report_mismatch("out_valid", o_out_valid, expected_results[0].out_valid);
                if (o_out_value !== expected_results[0].out_value)
                    report_mismatch("out_value", o_out_value, expected_results[0].out_value);
                if (o_halted !== expected_results[0].halted)
                    report_mismatch("halted", o_halted, expected_results[0].halted);
                if (o_div_error !== expected_results[0].div_error)
                    report_mismatch("div_error", o_div_error, expected_results[0].div_error);
                void'(expected_results.pop_front());
            end
        end
    end

    // Long receiver stall while the sender keeps offering, so the block backs up.
    initial begin
        wait (accepted_count >= 120);
        @(negedge i_clk);
        long_hold = 1'b1;
        repeat (LONG_STALL) @(negedge i_clk);
        long_hold = 1'b0;
    end

    initial begin
        // Directed part: extremes, every kind but ret and end, zero divisor, overflow division.
        queue_instr(K_PRELOAD, 10'd0, 10'd0, 10'd0, 10'd0, 32'sd0, 1'b0);
        queue_instr(K_PRELOAD, 10'd0, 10'd0, 10'd1023, 10'd0, INT_MAX, 1'b0);
        queue_instr(K_PRELOAD, 10'd0, 10'd0, 10'd4, 10'd0, INT_MIN, 1'b0);
        queue_instr(K_PRELOAD, 10'd0, 10'd0, 10'd8, 10'd0, -32'sd1, 1'b0);
        queue_instr(K_IN, 10'd0, 10'd0, 10'd12, 10'd0, 32'sd1, 1'b0);
        queue_instr(K_IN, 10'd0, 10'd0, 10'd16, 10'd0, pick_value(), 1'b0);
        queue_instr(K_COPY, 10'd16, 10'd0, 10'd20, 10'd0, 32'sd0, 1'b0);
        queue_instr(K_TEXT, 10'd1023, 10'd1023, 10'd1023, 10'd1023, INT_MIN, 1'b0);
        queue_instr(K_VOUT, 10'd1023, 10'd0, 10'd0, 10'd0, 32'sd0, 1'b0);
        queue_instr(K_VOUT, 10'd6, 10'd0, 10'd0, 10'd0, 32'sd0, 1'b0);
        queue_instr(K_ADD, 10'd1023, 10'd12, 10'd24, 10'd0, 32'sd0, 1'b0);
        queue_instr(K_SUB, 10'd4, 10'd12, 10'd28, 10'd0, 32'sd0, 1'b0);
        queue_instr(K_MUL, 10'd1023, 10'd1022, 10'd32, 10'd0, 32'sd0, 1'b0);
        queue_instr(K_DIV, 10'd4, 10'd8, 10'd24, 10'd0, 32'sd0, 1'b0);
        queue_instr(K_MOD, 10'd5, 10'd11, 10'd28, 10'd0, 32'sd0, 1'b0);
        queue_instr(K_DIV, 10'd16, 10'd0, 10'd20, 10'd0, 32'sd0, 1'b0);
        queue_instr(K_MOD, 10'd16, 10'd3, 10'd20, 10'd0, 32'sd0, 1'b0);
        queue_instr(K_GOTO, 10'd0, 10'd0, 10'd0, 10'd1023, 32'sd0, 1'b0);
        queue_instr(K_GOTO, 10'd0, 10'd0, 10'd0, 10'd0, 32'sd0, 1'b0);
        queue_instr(K_BEQ, 10'd0, 10'd2, 10'd0, 10'd1023, 32'sd0, 1'b0);
        queue_instr(K_BNE, 10'd4, 10'd1023, 10'd0, 10'd682, 32'sd0, 1'b0);
        queue_instr(K_BLT, 10'd4, 10'd1023, 10'd0, 10'd341, 32'sd0, 1'b0);
        queue_instr(K_BGT, 10'd4, 10'd1023, 10'd0, 10'd5, 32'sd0, 1'b0);
        queue_instr(K_BLE, 10'd1023, 10'd1023, 10'd0, 10'd7, 32'sd0, 1'b0);
        queue_instr(K_BGE, 10'd8, 10'd1023, 10'd0, 10'd9, 32'sd0, 1'b0);
        queue_instr(UNUSED_FIRST, 10'd0, 10'd0, 10'd0, 10'd0, 32'sd0, 1'b0);
        queue_instr(UNUSED_LAST, 10'd0, 10'd0, 10'd0, 10'd0, 32'sd0, 1'b0);

        // Random phases: none idle, sender idle, receiver stalls, both.
        for (int p = 0; p < 4; p++) begin
            phase_send_idle = (p == 1 || p == 3) ? ((p == 1) ? 72 : 33) : 0;
            phase_recv_idle = (p == 2 || p == 3) ? ((p == 2) ? 72 : 33) : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_random_instr(p == 1 && n == PHASE_ITEMS / 2);
        end

        // Halt, then a few items that must be ignored.
        queue_instr($urandom_range(1) ? K_RET : K_END, pick_source(), pick_source(),
                    10'd0, 10'd0, 32'sd0, 1'b0);
        for (int n = 0; n < 4; n++)
            queue_random_instr(1'b0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (accepted_count == total_items && expected_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb_three_address_code_executor_unit: done, clean");
        else
            $display("tb_three_address_code_executor_unit: done, errors");
        $finish;
    end
endmodule

@@ files.f @@
sv/tace_pkg.sv
sv/tace_div.sv
sv/three_address_code_executor_unit.sv
verif/tb_three_address_code_executor_unit.sv
